// ===== rtl/rfmr_pkg.sv =====
// Shared constants, codes and controller/datapath interface types for the reveal mask.
`timescale 1ns / 1ps
package rfmr_pkg;

    localparam int TEX_SIZE_DEF = 256;
    localparam logic [7:0] SMOOTH_Q8 = 8'd179;
    localparam logic [14:0] TGT_RECIP = 15'd27236;
    localparam int TGT_SHIFT = 21;
    localparam logic [19:0] COVER_RESET = 20'd16384;

    typedef enum logic [1:0] {
        CFG_ORIGIN_X   = 2'd0,
        CFG_ORIGIN_Y   = 2'd1,
        CFG_COVER_SIZE = 2'd2
    } t_cfg_idx;

    typedef enum logic {
        OP_REVEAL = 1'b0,
        OP_READ   = 1'b1
    } t_opcode;

    typedef enum logic [1:0] {
        DIV_X     = 2'd0,
        DIV_Y     = 2'd1,
        DIV_R     = 2'd2,
        DIV_RATIO = 2'd3
    } t_div_sel;

    typedef struct packed {
        logic     clr_write;
        logic     latch_in;
        logic     res_clear;
        logic     rd_issue;
        logic     rd_capture;
        logic     div_load;
        t_div_sel div_sel;
        logic     store_tx;
        logic     store_ty;
        logic     store_r;
        logic     box_set;
        logic     r2_set;
        logic     col_init;
        logic     col_next;
        logic     row_init;
        logic     row_next;
        logic     ax_latch;
        logic     ax_sq;
        logic     ay_latch;
        logic     ay_sq;
        logic     sq_load;
        logic     tgt1;
        logic     tgt2;
        logic     wr_min;
        logic     out_load;
    } t_cmd;

    typedef struct packed {
        logic    clr_last;
        t_opcode opcode;
        logic    div_done;
        logic    sq_done;
        logic    r_zero;
        logic    ax_out;
        logic    ay_out;
        logic    d2_out;
        logic    col_last;
        logic    row_last;
    } t_sts;

endpackage

// ===== rtl/radial_falloff_mask_reveal.sv =====
// Top level of the soft-circle reveal mask: controller, datapath and ports.
// Usage:
//   Input channel (i_valid/o_ready) carries one item: a reveal circle
//   (opcode 0) or a single texel read (opcode 1). Output channel
//   (o_valid/i_ready) returns one result per item: changed and texel_value.
//   Configuration (origin, cover size) is written through i_cfg_we,
//   i_cfg_index and i_cfg_data; the user must write it only while no item
//   is in flight, which the block itself does not enforce.
// Reset: the mask memory is swept to 255, one texel per cycle; o_ready stays
//   low until the sweep is done. Config registers return to reset values.
// A read issues the memory read, captures the texel and loads the output
//   register. A reveal first runs three divisions on the shared radix-2
//   divider, then walks the bounding box: columns and rows outside the
//   radius are skipped, a column or row inside it has its distance
//   squared, a texel failing the distance test is skipped, and a texel
//   inside runs a 31-step square root, an 8-step ratio divide, the
//   target and a read-modify-write of the mask memory.
// Items are handled one at a time. A finished result waits in the output
//   register while the next item is accepted; if the receiver stalls, the
//   block holds the next result until the output register is free.
`timescale 1ns / 1ps
module radial_falloff_mask_reveal #(
    parameter int TEX_SIZE = rfmr_pkg::TEX_SIZE_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic               i_opcode,
    input  logic signed [31:0] i_center_x,
    input  logic signed [31:0] i_center_y,
    input  logic [23:0]        i_reveal_radius,
    input  logic [7:0]         i_read_col,
    input  logic [7:0]         i_read_row,
    output logic               o_valid,
    input  logic               i_ready,
    output logic               o_changed,
    output logic [7:0]         o_texel_value,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data
);

    rfmr_pkg::t_cmd cmd;
    rfmr_pkg::t_sts sts;

    rfmr_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_cmd   (cmd),
        .i_sts   (sts)
    );

    rfmr_dp #(
        .TEX_SIZE (TEX_SIZE)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_opcode        (i_opcode),
        .i_center_x      (i_center_x),
        .i_center_y      (i_center_y),
        .i_reveal_radius (i_reveal_radius),
        .i_read_col      (i_read_col),
        .i_read_row      (i_read_row),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .o_changed       (o_changed),
        .o_texel_value   (o_texel_value)
    );

endmodule

// ===== rtl/rfmr_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module rfmr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/rfmr_dp.sv =====
// Datapath: config registers, shared divider, square root, texel walk and mask memory.
`timescale 1ns / 1ps
module rfmr_dp #(
    parameter int TEX_SIZE = rfmr_pkg::TEX_SIZE_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  rfmr_pkg::t_cmd      i_cmd,
    output rfmr_pkg::t_sts      o_sts,
    input  logic                i_opcode,
    input  logic signed [31:0]  i_center_x,
    input  logic signed [31:0]  i_center_y,
    input  logic [23:0]         i_reveal_radius,
    input  logic [7:0]          i_read_col,
    input  logic [7:0]          i_read_row,
    input  logic                i_cfg_we,
    input  logic [1:0]          i_cfg_index,
    input  logic [31:0]         i_cfg_data,
    output logic                o_changed,
    output logic [7:0]          o_texel_value
);

    localparam int TL    = $clog2(TEX_SIZE);
    localparam int NW    = 32 + TL;
    localparam int TXW   = NW + 2;
    localparam int EW    = TXW + 1;
    localparam int RRW   = 24 + TL;
    localparam int AW    = 2 * TL;
    localparam int CW    = $clog2(NW + 1);
    localparam int DEPTH = TEX_SIZE * TEX_SIZE;
    localparam logic [TXW-1:0] HALF = TXW'(TEX_SIZE * 128);
    localparam logic [TL-1:0]  IMAX = TL'(TEX_SIZE - 1);
    localparam logic [60:0]    SQ_TOP = 61'(1) << 60;

    function automatic logic [TL-1:0] clamp_box(input logic signed [EW-1:0] v);
        logic signed [EW-1:0] q;
        logic [TL-1:0] res;
        q = v >>> 8;
        if (q < 0) begin
            res = '0;
        end else if (q > $signed(EW'(TEX_SIZE - 1))) begin
            res = IMAX;
        end else begin
            res = q[TL-1:0];
        end
        return res;
    endfunction

    function automatic logic [EW-1:0] dist_mag(input logic [TL-1:0] idx,
                                              input logic signed [TXW-1:0] t,
                                              input logic [2:0] sh);
        logic signed [EW-1:0] e;
        logic [EW-1:0] m;
        e = $signed(EW'({idx, 8'h00})) - EW'(t);
        m = e[EW-1] ? -e : e;
        return m >> sh;
    endfunction

    // config and latched item
    logic signed [31:0] r_ox, r_oy, r_cx, r_cy;
    logic [19:0]        r_cover;
    logic [23:0]        r_rad;
    logic [7:0]         r_rcol, r_rrow;
    logic               r_op, r_oob;

    // divider
    logic [29:0]   r_dv_rem, r_dv_den;
    logic [NW-1:0] r_dv_quo;
    logic [CW-1:0] r_dv_cnt;
    logic          r_dv_neg;

    // square root
    logic [60:0] r_sq_v, r_sq_res, r_sq_bit;

    // geometry
    logic signed [TXW-1:0] r_tx, r_ty;
    logic [RRW-1:0]        r_r;
    logic [2:0]            r_s;
    logic [29:0]           r_rs, r_ax, r_ay;
    logic [59:0]           r_r2, r_ax2, r_ay2;
    logic [TL-1:0]         r_x0, r_x1, r_y0, r_y1, r_i, r_j;

    // texel update and result
    logic [7:0]  r_old, r_tgt, r_tex, r_out_tex;
    logic [14:0] r_n;
    logic        r_tz, r_chg, r_out_chg;

    logic [19:0]           cov;
    logic signed [32:0]    diff_x, diff_y;
    logic [32:0]           mag_x, mag_y;
    logic [29:0]           ld_rem, ld_den;
    logic [NW-1:0]         ld_quo;
    logic [CW-1:0]         ld_cnt;
    logic                  ld_neg;
    logic [30:0]           dv_trial;
    logic                  dv_ge;
    logic [29:0]           dv_rem_n;
    logic [TXW-1:0]        qe, qf, tnew;
    logic [2:0]            s_c;
    logic [29:0]           rs_c;
    logic signed [EW-1:0]  tx_e, ty_e, r_e;
    logic [EW-1:0]         ax_full, ay_full;
    logic [60:0]           d2, sq_t;
    logic                  sq_ge;
    logic [7:0]            ratio;
    logic [6:0]            k7;
    logic [29:0]           prod;
    logic                  tgt_lt;
    logic                  ram_we;
    logic [7:0]            ram_wdata, ram_rdata;
    logic [AW-1:0]         ram_waddr, ram_raddr;

    assign cov    = (r_cover == '0) ? 20'd1 : r_cover;
    assign diff_x = 33'(r_cx) - 33'(r_ox);
    assign diff_y = 33'(r_cy) - 33'(r_oy);
    assign mag_x  = diff_x[32] ? -diff_x : diff_x;
    assign mag_y  = diff_y[32] ? -diff_y : diff_y;

    always_comb begin
        ld_rem = '0;
        ld_den = 30'(cov);
        ld_cnt = CW'(NW);
        ld_neg = 1'b0;
        ld_quo = '0;
        case (i_cmd.div_sel)
            rfmr_pkg::DIV_X: begin
                ld_quo = {mag_x[31:0], {TL{1'b0}}};
                ld_neg = diff_x[32];
            end
            rfmr_pkg::DIV_Y: begin
                ld_quo = {mag_y[31:0], {TL{1'b0}}};
                ld_neg = diff_y[32];
            end
            rfmr_pkg::DIV_R: begin
                ld_quo = NW'({r_rad, {TL{1'b0}}});
            end
            rfmr_pkg::DIV_RATIO: begin
                ld_rem = r_sq_res[29:0];
                ld_den = r_rs;
                ld_cnt = CW'(8);
            end
            default: begin
                ld_quo = '0;
            end
        endcase
    end

    assign dv_trial = {r_dv_rem, r_dv_quo[NW-1]};
    assign dv_ge    = dv_trial >= {1'b0, r_dv_den};
    assign dv_rem_n = dv_ge ? 30'(dv_trial - {1'b0, r_dv_den}) : dv_trial[29:0];

    assign qe   = TXW'(r_dv_quo);
    assign qf   = r_dv_neg ? -(qe + TXW'(|r_dv_rem)) : qe;
    assign tnew = qf + HALF;

    always_comb begin
        s_c = 3'd7;
        for (int k = 7; k >= 0; k--) begin
            if ((64'(r_r) >> k) < 64'h4000_0000) begin
                s_c = 3'(k);
            end
        end
    end
    assign rs_c = 30'(r_r >> s_c);

    assign tx_e = EW'(r_tx);
    assign ty_e = EW'(r_ty);
    assign r_e  = $signed(EW'(r_r));

    assign ax_full = dist_mag(r_i, r_tx, r_s);
    assign ay_full = dist_mag(r_j, r_ty, r_s);

    assign d2    = 61'(r_ax2) + 61'(r_ay2);
    assign sq_t  = r_sq_res + r_sq_bit;
    assign sq_ge = r_sq_v >= sq_t;

    assign ratio  = r_dv_quo[7:0];
    assign k7     = 7'(ratio - rfmr_pkg::SMOOTH_Q8);
    assign prod   = 30'(r_n) * 30'(rfmr_pkg::TGT_RECIP);
    assign tgt_lt = r_tgt < r_old;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ox     <= '0;
            r_oy     <= '0;
            r_cover  <= rfmr_pkg::COVER_RESET;
            r_i      <= '0;
            r_j      <= '0;
            r_dv_cnt <= '0;
            r_sq_bit <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    rfmr_pkg::CFG_ORIGIN_X:   r_ox <= i_cfg_data;
                    rfmr_pkg::CFG_ORIGIN_Y:   r_oy <= i_cfg_data;
                    rfmr_pkg::CFG_COVER_SIZE: r_cover <= i_cfg_data[19:0];
                    default: begin
                    end
                endcase
            end
            if (i_cmd.clr_write) begin
                r_i <= r_i + 1'b1;
                if (r_i == IMAX) begin
                    r_j <= r_j + 1'b1;
                end
            end else begin
                if (i_cmd.col_init) begin
                    r_i <= r_x0;
                end else if (i_cmd.col_next) begin
                    r_i <= r_i + 1'b1;
                end
                if (i_cmd.row_init) begin
                    r_j <= r_y0;
                end else if (i_cmd.row_next) begin
                    r_j <= r_j + 1'b1;
                end
            end
            if (i_cmd.div_load) begin
                r_dv_cnt <= ld_cnt;
            end else if (r_dv_cnt != '0) begin
                r_dv_cnt <= r_dv_cnt - 1'b1;
            end
            if (i_cmd.sq_load) begin
                r_sq_bit <= SQ_TOP;
            end else if (r_sq_bit != '0) begin
                r_sq_bit <= r_sq_bit >> 2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_in) begin
            r_op   <= i_opcode;
            r_cx   <= i_center_x;
            r_cy   <= i_center_y;
            r_rad  <= i_reveal_radius;
            r_rcol <= i_read_col;
            r_rrow <= i_read_row;
            r_oob  <= (32'(i_read_col) >= 32'(TEX_SIZE)) || (32'(i_read_row) >= 32'(TEX_SIZE));
        end
        if (i_cmd.div_load) begin
            r_dv_rem <= ld_rem;
            r_dv_quo <= ld_quo;
            r_dv_den <= ld_den;
            r_dv_neg <= ld_neg;
        end else if (r_dv_cnt != '0) begin
            r_dv_rem <= dv_rem_n;
            r_dv_quo <= {r_dv_quo[NW-2:0], dv_ge};
        end
        if (i_cmd.store_tx) begin
            r_tx <= tnew;
        end
        if (i_cmd.store_ty) begin
            r_ty <= tnew;
        end
        if (i_cmd.store_r) begin
            r_r <= r_dv_quo[RRW-1:0];
        end
        if (i_cmd.box_set) begin
            r_s  <= s_c;
            r_rs <= rs_c;
            r_x0 <= clamp_box(tx_e - r_e);
            r_x1 <= clamp_box(tx_e + r_e);
            r_y0 <= clamp_box(ty_e - r_e);
            r_y1 <= clamp_box(ty_e + r_e);
        end
        if (i_cmd.r2_set) begin
            r_r2 <= r_rs * r_rs;
        end
        if (i_cmd.ax_latch) begin
            r_ax <= ax_full[29:0];
        end
        if (i_cmd.ax_sq) begin
            r_ax2 <= r_ax * r_ax;
        end
        if (i_cmd.ay_latch) begin
            r_ay <= ay_full[29:0];
        end
        if (i_cmd.ay_sq) begin
            r_ay2 <= r_ay * r_ay;
        end
        if (i_cmd.sq_load) begin
            r_sq_v   <= d2;
            r_sq_res <= '0;
            r_old    <= ram_rdata;
        end else if (r_sq_bit != '0) begin
            if (sq_ge) begin
                r_sq_v   <= r_sq_v - sq_t;
                r_sq_res <= (r_sq_res >> 1) + r_sq_bit;
            end else begin
                r_sq_res <= r_sq_res >> 1;
            end
        end
        if (i_cmd.tgt1) begin
            r_tz <= ratio <= rfmr_pkg::SMOOTH_Q8;
            r_n  <= {k7, 8'h00} - 15'(k7);
        end
        if (i_cmd.tgt2) begin
            r_tgt <= r_tz ? 8'd0 : prod[rfmr_pkg::TGT_SHIFT+7:rfmr_pkg::TGT_SHIFT];
        end
        if (i_cmd.res_clear) begin
            r_chg <= 1'b0;
            r_tex <= '0;
        end else begin
            if (i_cmd.wr_min && tgt_lt) begin
                r_chg <= 1'b1;
            end
            if (i_cmd.rd_capture) begin
                r_tex <= r_oob ? 8'd0 : ram_rdata;
            end
        end
        if (i_cmd.out_load) begin
            r_out_chg <= r_chg;
            r_out_tex <= r_tex;
        end
    end

    assign ram_we    = i_cmd.clr_write || (i_cmd.wr_min && tgt_lt);
    assign ram_wdata = i_cmd.clr_write ? 8'hFF : r_tgt;
    assign ram_waddr = {r_j, r_i};
    assign ram_raddr = i_cmd.rd_issue ? {TL'(r_rrow), TL'(r_rcol)} : {r_j, r_i};

    rfmr_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_mask (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        o_sts          = '0;
        o_sts.clr_last = (r_i == IMAX) && (r_j == IMAX);
        o_sts.opcode   = rfmr_pkg::t_opcode'(r_op);
        o_sts.div_done = r_dv_cnt == '0;
        o_sts.sq_done  = r_sq_bit == '0;
        o_sts.r_zero   = r_r == '0;
        o_sts.ax_out   = ax_full >= EW'(r_rs);
        o_sts.ay_out   = ay_full >= EW'(r_rs);
        o_sts.d2_out   = d2 >= 61'(r_r2);
        o_sts.col_last = r_i == r_x1;
        o_sts.row_last = r_j == r_y1;
    end

    assign o_changed     = r_out_chg;
    assign o_texel_value = r_out_tex;

endmodule

// ===== rtl/rfmr_ctrl.sv =====
// Controller: sequences clearing, reads, setup divisions and the per-texel walk.
`timescale 1ns / 1ps
module rfmr_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    output logic           o_valid,
    input  logic           i_ready,
    output rfmr_pkg::t_cmd o_cmd,
    input  rfmr_pkg::t_sts i_sts
);

    typedef enum logic [18:0] {
        S_CLR  = 19'h00001,
        S_IDLE = 19'h00002,
        S_DISP = 19'h00004,
        S_RDD  = 19'h00008,
        S_DXW  = 19'h00010,
        S_DYW  = 19'h00020,
        S_DRW  = 19'h00040,
        S_BOX  = 19'h00080,
        S_R2   = 19'h00100,
        S_COL  = 19'h00200,
        S_AXSQ = 19'h00400,
        S_ROW  = 19'h00800,
        S_AYSQ = 19'h01000,
        S_D2   = 19'h02000,
        S_SQRT = 19'h04000,
        S_RATW = 19'h08000,
        S_TGT2 = 19'h10000,
        S_WR   = 19'h20000,
        S_DONE = 19'h40000
    } t_state;

    t_state r_state, n_state, adv_state;
    logic   r_o_valid;

    assign adv_state = !i_sts.row_last ? S_ROW : (i_sts.col_last ? S_DONE : S_COL);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_CLR: begin
                o_cmd.clr_write = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.latch_in  = 1'b1;
                    o_cmd.res_clear = 1'b1;
                    n_state         = S_DISP;
                end
            end
            S_DISP: begin
                if (i_sts.opcode == rfmr_pkg::OP_READ) begin
                    o_cmd.rd_issue = 1'b1;
                    n_state        = S_RDD;
                end else begin
                    o_cmd.div_load = 1'b1;
                    o_cmd.div_sel  = rfmr_pkg::DIV_X;
                    n_state        = S_DXW;
                end
            end
            S_RDD: begin
                o_cmd.rd_capture = 1'b1;
                n_state          = S_DONE;
            end
            S_DXW: begin
                if (i_sts.div_done) begin
                    o_cmd.store_tx = 1'b1;
                    o_cmd.div_load = 1'b1;
                    o_cmd.div_sel  = rfmr_pkg::DIV_Y;
                    n_state        = S_DYW;
                end
            end
            S_DYW: begin
                if (i_sts.div_done) begin
                    o_cmd.store_ty = 1'b1;
                    o_cmd.div_load = 1'b1;
                    o_cmd.div_sel  = rfmr_pkg::DIV_R;
                    n_state        = S_DRW;
                end
            end
            S_DRW: begin
                if (i_sts.div_done) begin
                    o_cmd.store_r = 1'b1;
                    n_state       = S_BOX;
                end
            end
            S_BOX: begin
                if (i_sts.r_zero) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.box_set = 1'b1;
                    n_state       = S_R2;
                end
            end
            S_R2: begin
                o_cmd.r2_set   = 1'b1;
                o_cmd.col_init = 1'b1;
                n_state        = S_COL;
            end
            S_COL: begin
                if (!i_sts.ax_out) begin
                    o_cmd.ax_latch = 1'b1;
                    n_state        = S_AXSQ;
                end else if (i_sts.col_last) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.col_next = 1'b1;
                end
            end
            S_AXSQ: begin
                o_cmd.ax_sq    = 1'b1;
                o_cmd.row_init = 1'b1;
                n_state        = S_ROW;
            end
            S_ROW: begin
                if (!i_sts.ay_out) begin
                    o_cmd.ay_latch = 1'b1;
                    n_state        = S_AYSQ;
                end else begin
                    o_cmd.row_next = !i_sts.row_last;
                    o_cmd.col_next = i_sts.row_last && !i_sts.col_last;
                    n_state        = adv_state;
                end
            end
            S_AYSQ: begin
                o_cmd.ay_sq = 1'b1;
                n_state     = S_D2;
            end
            S_D2: begin
                if (!i_sts.d2_out) begin
                    o_cmd.sq_load = 1'b1;
                    n_state       = S_SQRT;
                end else begin
                    o_cmd.row_next = !i_sts.row_last;
                    o_cmd.col_next = i_sts.row_last && !i_sts.col_last;
                    n_state        = adv_state;
                end
            end
            S_SQRT: begin
                if (i_sts.sq_done) begin
                    o_cmd.div_load = 1'b1;
                    o_cmd.div_sel  = rfmr_pkg::DIV_RATIO;
                    n_state        = S_RATW;
                end
            end
            S_RATW: begin
                if (i_sts.div_done) begin
                    o_cmd.tgt1 = 1'b1;
                    n_state    = S_TGT2;
                end
            end
            S_TGT2: begin
                o_cmd.tgt2 = 1'b1;
                n_state    = S_WR;
            end
            S_WR: begin
                o_cmd.wr_min   = 1'b1;
                o_cmd.row_next = !i_sts.row_last;
                o_cmd.col_next = i_sts.row_last && !i_sts.col_last;
                n_state        = adv_state;
            end
            S_DONE: begin
                if (!r_o_valid || i_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLR;
            r_o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.out_load) begin
                r_o_valid <= 1'b1;
            end else if (i_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    assign o_ready = r_state == S_IDLE;
    assign o_valid = r_o_valid;

endmodule

// ===== rtl/rfmr_chk.sv =====
// Port-level checker for the reveal mask, bound to the top level.
`timescale 1ns / 1ps
module rfmr_chk (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_valid,
    input logic               o_ready,
    input logic               i_opcode,
    input logic signed [31:0] i_center_x,
    input logic signed [31:0] i_center_y,
    input logic [23:0]        i_reveal_radius,
    input logic [7:0]         i_read_col,
    input logic [7:0]         i_read_row,
    input logic               o_valid,
    input logic               i_ready,
    input logic               o_changed,
    input logic [7:0]         o_texel_value,
    input logic               i_cfg_we,
    input logic [1:0]         i_cfg_index,
    input logic [31:0]        i_cfg_data
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_changed) && $stable(o_texel_value))
        else $error("result changed while stalled");

    a_field_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_changed && (o_texel_value != 8'd0)))
        else $error("changed set together with a texel value");

    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("second transfer taken while busy");

    a_clear_blocks: assert property (@(posedge i_clk)
        $rose(i_rst_n) |-> !o_ready)
        else $error("ready during clearing pass");

endmodule

bind radial_falloff_mask_reveal rfmr_chk u_rfmr_chk (.*);

// ===== tb/tb_radial_falloff_mask_reveal.sv =====
// Self-checking testbench for the soft-circle reveal mask against a local predictor.
`timescale 1ns / 1ps
module tb_radial_falloff_mask_reveal;

    localparam int TS = 256;
    localparam logic [1:0] CFG_UNUSED = 2'd3;

    typedef struct {
        rfmr_pkg::t_opcode  op;
        logic signed [31:0] cx;
        logic signed [31:0] cy;
        logic [23:0]        rad;
        logic [7:0]         col;
        logic [7:0]         row;
    } t_item;

    typedef struct {
        logic       changed;
        logic [7:0] texel;
    } t_result;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_ready;
    logic i_opcode = 1'b0;
    logic signed [31:0] i_center_x = '0;
    logic signed [31:0] i_center_y = '0;
    logic [23:0] i_reveal_radius = '0;
    logic [7:0] i_read_col = '0;
    logic [7:0] i_read_row = '0;
    logic o_valid;
    logic i_ready = 1'b0;
    logic o_changed;
    logic [7:0] o_texel_value;
    logic i_cfg_we = 1'b0;
    logic [1:0] i_cfg_index = '0;
    logic [31:0] i_cfg_data = '0;

    radial_falloff_mask_reveal i_dut (.*);

    always #6 i_clk = ~i_clk;

    byte unsigned texels[TS*TS];
    longint mx_origin_x, mx_origin_y, mx_cover;
    t_item pending_items[$];
    t_result expected_results[$];
    t_item held_item;
    int send_idle_pct = 26;
    int recv_idle_pct = 76;
    int mismatches = 0;

    function automatic longint floor_div(longint num, longint den);
        if (num >= 0) return num / den;
        return -((-num + den - 1) / den);
    endfunction

    function automatic int clamp_texel(longint v);
        if (v < 0) return 0;
        if (v > TS - 1) return TS - 1;
        return int'(v);
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv >>= 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v -= res + bitv;
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    function automatic logic apply_reveal(t_item it);
        longint cov, tx, ty, r, ex, ey;
        longint unsigned rs, r2, ax, ay, d2, ratio, tgt;
        int sh, x0, x1, y0, y1;
        logic hit;
        hit = 1'b0;
        cov = (mx_cover == 0) ? 1 : mx_cover;
        tx = floor_div((longint'(it.cx) - mx_origin_x) * TS, cov) + (TS / 2) * 256;
        ty = floor_div((longint'(it.cy) - mx_origin_y) * TS, cov) + (TS / 2) * 256;
        r = longint'(it.rad) * TS / cov;
        if (r <= 0) return 1'b0;
        sh = 0;
        while ((r >>> sh) >= (longint'(1) << 30)) sh++;
        rs = longint'(r) >> sh;
        r2 = rs * rs;
        x0 = clamp_texel(floor_div(tx - r, 256));
        x1 = clamp_texel(floor_div(tx + r, 256));
        y0 = clamp_texel(floor_div(ty - r, 256));
        y1 = clamp_texel(floor_div(ty + r, 256));
        for (int i = x0; i <= x1; i++) begin
            ex = longint'(i) * 256 - tx;
            ax = (ex < 0 ? -ex : ex) >> sh;
            if (ax >= rs) continue;
            for (int j = y0; j <= y1; j++) begin
                ey = longint'(j) * 256 - ty;
                ay = (ey < 0 ? -ey : ey) >> sh;
                if (ay >= rs) continue;
                d2 = ax * ax + ay * ay;
                if (d2 >= r2) continue;
                ratio = (int_sqrt(d2) * 256) / rs;
                if (ratio > 255) ratio = 255;
                tgt = (ratio <= rfmr_pkg::SMOOTH_Q8) ? 0 :
                      (ratio - rfmr_pkg::SMOOTH_Q8) * 255 / 77;
                if (tgt < texels[j*TS + i]) begin
                    texels[j*TS + i] = byte'(tgt);
                    hit = 1'b1;
                end
            end
        end
        return hit;
    endfunction

    function automatic t_result predict_result(t_item it);
        t_result res;
        res.changed = 1'b0;
        res.texel = '0;
        if (it.op == rfmr_pkg::OP_REVEAL) res.changed = apply_reveal(it);
        else res.texel = texels[int'(it.row)*TS + int'(it.col)];
        return res;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || o_ready) begin
            if (i_valid) expected_results.push_back(predict_result(held_item));
            if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                held_item = pending_items.pop_front();
                i_valid <= 1'b1;
                i_opcode <= held_item.op;
                i_center_x <= held_item.cx;
                i_center_y <= held_item.cy;
                i_reveal_radius <= held_item.rad;
                i_read_col <= held_item.col;
                i_read_row <= held_item.row;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        t_result exp_res;
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result changed=%0d texel=%0d",
                                               o_changed, o_texel_value);
            end else begin
                exp_res = expected_results.pop_front();
                if (o_changed !== exp_res.changed || o_texel_value !== exp_res.texel) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: changed exp %0d got %0d, texel exp %0d got %0d",
                                 exp_res.changed, o_changed, exp_res.texel, o_texel_value);
                end
            end
        end
        i_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    function automatic t_item make_reveal(longint off_x, longint off_y, longint rt);
        t_item it;
        longint cov, rad;
        cov = (mx_cover == 0) ? 1 : mx_cover;
        rad = rt * cov / 256;
        if (rad > 24'hFFFFFF) rad = 24'hFFFFFF;
        it.op = rfmr_pkg::OP_REVEAL;
        it.cx = 32'(mx_origin_x + off_x * cov / 256);
        it.cy = 32'(mx_origin_y + off_y * cov / 256);
        it.rad = 24'(rad);
        it.col = 8'($urandom);
        it.row = 8'($urandom);
        return it;
    endfunction

    function automatic t_item make_read(int c, int r);
        t_item it;
        it.op = rfmr_pkg::OP_READ;
        it.cx = 32'($urandom);
        it.cy = 32'($urandom);
        it.rad = 24'($urandom);
        it.col = 8'(c);
        it.row = 8'(r);
        return it;
    endfunction

    function automatic t_item make_random_item();
        t_item it;
        int pick;
        longint dx, dy;
        pick = $urandom_range(99);
        if (pick < 62) begin
            it = make_reveal($signed($urandom_range(0, 300*256)) - 150*256,
                             $signed($urandom_range(0, 300*256)) - 150*256,
                             $urandom_range(0, 1100));
        end else if (pick < 94) begin
            if ($urandom_range(1))
                it = make_read($urandom_range(255), $urandom_range(255));
            else
                it = make_read($urandom_range(100, 156), $urandom_range(100, 156));
        end else begin
            it.op = rfmr_pkg::OP_REVEAL;
            it.cx = 32'($urandom);
            it.cy = 32'($urandom);
            it.col = 8'($urandom);
            it.row = 8'($urandom);
            dx = longint'(it.cx) - mx_origin_x;
            dy = longint'(it.cy) - mx_origin_y;
            if ((dx < 0 ? -dx : dx) > (longint'(1) << 28) ||
                (dy < 0 ? -dy : dy) > (longint'(1) << 28))
                it.rad = 24'($urandom);
            else
                it.rad = 24'($urandom_range(0, 255));
        end
        return it;
    endfunction

    task automatic write_reg(logic [1:0] idx, logic [31:0] data);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        case (idx)
            rfmr_pkg::CFG_ORIGIN_X: mx_origin_x = longint'($signed(data));
            rfmr_pkg::CFG_ORIGIN_Y: mx_origin_y = longint'($signed(data));
            rfmr_pkg::CFG_COVER_SIZE: mx_cover = longint'(data[19:0]);
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic drain();
        @(negedge i_clk);
        while (pending_items.size() > 0 || i_valid || expected_results.size() > 0)
            @(negedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic run_random(int count);
        repeat (count) pending_items.push_back(make_random_item());
        drain();
    endtask

    initial begin
        foreach (texels[k]) texels[k] = 8'hFF;
        mx_origin_x = 0;
        mx_origin_y = 0;
        mx_cover = rfmr_pkg::COVER_RESET;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        pending_items.push_back(make_read(0, 0));
        pending_items.push_back(make_read(255, 255));
        pending_items.push_back(make_reveal(0, 0, 0));
        pending_items.push_back(make_reveal(0, 0, 3*256));
        pending_items.push_back(make_reveal(0, 0, 3*256));
        pending_items.push_back(make_read(128, 128));
        pending_items.push_back(make_read(130, 128));
        pending_items.push_back(make_read(127, 126));
        pending_items.push_back(make_reveal(-128*256, -128*256, 2*256));
        pending_items.push_back(make_read(0, 0));
        pending_items.push_back(make_reveal(127*256, 127*256, 600));
        pending_items.push_back(make_read(255, 255));
        pending_items.push_back(make_reveal(400*256, 0, 4*256));
        begin
            t_item far_item;
            far_item = make_read(0, 0);
            far_item.op = rfmr_pkg::OP_REVEAL;
            far_item.cx = 32'h7FFF_FFFF;
            far_item.cy = 32'h7FFF_FFFF;
            far_item.rad = 24'hFF_FFFF;
            pending_items.push_back(far_item);
            far_item.cx = 32'h8000_0000;
            far_item.cy = 32'h8000_0000;
            pending_items.push_back(far_item);
            far_item.cy = 32'h0000_0000;
            pending_items.push_back(far_item);
        end
        pending_items.push_back(make_reveal(60*256, -40*256, 1));
        pending_items.push_back(make_reveal(-30*256 + 77, 20*256 + 200, 1500));
        pending_items.push_back(make_read(98, 148));
        drain();

        run_random(87);

        write_reg(rfmr_pkg::CFG_COVER_SIZE, 32'd1);
        write_reg(rfmr_pkg::CFG_ORIGIN_X, 32'h7FFF_FF00);
        write_reg(rfmr_pkg::CFG_ORIGIN_Y, 32'h7FFF_FFFF);
        run_random(95);

        send_idle_pct = 76;
        recv_idle_pct = 26;
        write_reg(rfmr_pkg::CFG_COVER_SIZE, 32'hFFFF_FFFF);
        write_reg(rfmr_pkg::CFG_ORIGIN_X, 32'h8000_0000);
        write_reg(rfmr_pkg::CFG_ORIGIN_Y, 32'h8000_0001);
        run_random(95);

        write_reg(rfmr_pkg::CFG_COVER_SIZE, 32'd0);
        write_reg(rfmr_pkg::CFG_ORIGIN_X, $urandom);
        write_reg(rfmr_pkg::CFG_ORIGIN_Y, $urandom);
        run_random(95);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_reg(CFG_UNUSED, $urandom);
        write_reg(rfmr_pkg::CFG_COVER_SIZE, 32'd3000);
        run_random(95);

        write_reg(rfmr_pkg::CFG_COVER_SIZE, 32'd16384);
        write_reg(rfmr_pkg::CFG_ORIGIN_X, 32'($signed($urandom_range(0, 20000)) - 10000));
        write_reg(rfmr_pkg::CFG_ORIGIN_Y, 32'($signed($urandom_range(0, 20000)) - 10000));
        run_random(95);

        repeat (200) @(posedge i_clk);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("tb_radial_falloff_mask_reveal passed");
        else
            $display("tb_radial_falloff_mask_reveal failed");
        $finish;
    end

    initial begin
        #80_000_000;
        $display("tb_radial_falloff_mask_reveal failed");
        $finish;
    end

endmodule
